// ----- src/tps_pkg.sv -----
// shared types, constants and register codes for the tachometer speed block
package tps_pkg;

    // timestamp width and derived widths
    localparam int STAMP_BITS = 24;
    localparam int CMP_BITS   = (STAMP_BITS > 24) ? STAMP_BITS : 24;
    localparam int NUM_BITS   = 32;
    localparam int DIV_BITS   = 24;
    localparam int SPD_BITS   = 16;
    localparam int CNT_BITS   = $clog2(NUM_BITS);

    // register reset values
    localparam logic [23:0] PERIOD_LIMIT_RST = 24'd1400000;
    localparam logic [31:0] NUMERATOR_RST    = 32'd200000000;
    localparam logic [15:0] MAX_SPEED_RST    = 16'd1000;
    localparam logic [15:0] MIN_SPEED_RST    = 16'd0;

    typedef logic [STAMP_BITS-1:0] t_stamp;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_PERIOD_LIMIT = 2'd0,
        REG_NUMERATOR    = 2'd1,
        REG_MAX_SPEED    = 2'd2,
        REG_MIN_SPEED    = 2'd3
    } t_reg_idx;

    // controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic prep;
        logic div_step;
        logic load_out;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic skip_div;
    } t_status;

endpackage

// ----- src/tachometer_period_to_speed.sv -----
// top level: tachometer capture stamps in, period and speed words out
// Each input word is a down-counting timer stamp taken at a tachometer edge;
// each produces one output word with the period since the previous edge (capped
// at period_limit) and the speed speed_numerator / period in 0.1 RPS units,
// saturated to 16 bits and clamped to [min_speed, max_speed]. The first edge
// after reset gives valid_res = 0 with zero period and speed. A word that needs
// a division goes through accept, setup, 32 steps of the restoring divider at
// one quotient bit per cycle, and result load; the first edge and a zero period
// skip the divider. The divider is a single unit shared by all words, so a new
// word is accepted only once the last one is through. Results sit in an output
// register, so the next word is accepted while a result waits to be taken.
module tachometer_period_to_speed (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [23:0] i_capture_time,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [23:0] o_period,
    output logic [15:0] o_speed,
    output logic        o_valid_res
);
    import tps_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // sequencer
    tps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // arithmetic and storage
    tps_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_capture_time (i_capture_time),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .o_period       (o_period),
        .o_speed        (o_speed),
        .o_valid_res    (o_valid_res)
    );

endmodule

// ----- src/tps_ctrl.sv -----
// controller state machine: sequences capture, setup, divide and result load
module tps_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  tps_pkg::t_status i_status,
    output tps_pkg::t_cmd    o_cmd
);
    import tps_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PREP = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_FIN  = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic                r_out_valid, n_out_valid;
    logic                w_accept;
    logic                w_can_load;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_can_load  = !r_out_valid || i_out_ready;

    // next state and command decode
    always_comb begin
        n_state          = r_state;
        n_cnt            = r_cnt;
        o_cmd            = '0;
        o_cmd.load_in    = w_accept;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_cnt      = CNT_BITS'(NUM_BITS - 1);
                n_state    = i_status.skip_div ? ST_FIN : ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt - CNT_BITS'(1);
                if (r_cnt == '0) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (w_can_load) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // output word valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // result is never loaded over a word that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over a pending word");

    // an accepted word always moves on to setup
    a_accept_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_PREP))
        else $error("accepted word did not enter setup");

    // the last divide step hands over to finish
    a_div_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && r_cnt == '0) |=> (r_state == ST_FIN))
        else $error("divider did not finish after last step");

    // a pending word only leaves when taken
    a_out_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_out_valid) |-> ($past(i_out_ready) || !$past(i_rst_n)))
        else $error("output word dropped without handshake");

endmodule

// ----- src/tps_dp.sv -----
// datapath: config registers, stamp history, period cap, divider and clamps
module tps_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic [23:0]          i_capture_time,
    input  tps_pkg::t_cmd        i_cmd,
    output tps_pkg::t_status     o_status,
    output logic [23:0]          o_period,
    output logic [15:0]          o_speed,
    output logic                 o_valid_res
);
    import tps_pkg::*;

    // configuration
    logic [23:0]         r_period_limit;
    logic [31:0]         r_numerator;
    logic [15:0]         r_max_speed;
    logic [15:0]         r_min_speed;

    // edge history
    t_stamp              r_prev;
    logic                r_seen;
    t_stamp              r_stamp;
    t_stamp              r_old;
    logic                r_first;

    // divider
    logic [DIV_BITS-1:0] r_div;
    logic [DIV_BITS-1:0] r_rem;
    logic [NUM_BITS-1:0] r_quo;
    logic [23:0]         r_period;

    // output word
    logic [23:0]         r_out_period;
    logic [15:0]         r_out_speed;
    logic                r_out_valid_res;

    t_stamp              w_ticks;
    logic [CMP_BITS-1:0] w_ticks_ext;
    logic [23:0]         w_period;
    logic [DIV_BITS:0]   w_shift;
    logic [DIV_BITS:0]   w_div_ext;
    logic                w_ge;
    logic [SPD_BITS-1:0] w_sat;
    logic [SPD_BITS-1:0] w_speed;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_limit <= PERIOD_LIMIT_RST;
            r_numerator    <= NUMERATOR_RST;
            r_max_speed    <= MAX_SPEED_RST;
            r_min_speed    <= MIN_SPEED_RST;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_PERIOD_LIMIT: r_period_limit <= i_cfg_data[23:0];
                REG_NUMERATOR:    r_numerator    <= i_cfg_data;
                REG_MAX_SPEED:    r_max_speed    <= i_cfg_data[15:0];
                REG_MIN_SPEED:    r_min_speed    <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // stamp history, updated at accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_seen <= 1'b0;
        end else if (i_cmd.load_in) begin
            r_prev <= t_stamp'(i_capture_time);
            r_seen <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_stamp <= t_stamp'(i_capture_time);
            r_old   <= r_prev;
            r_first <= !r_seen;
        end
    end

    // period: wrapped difference of down-counting stamps, capped
    assign w_ticks     = r_old - r_stamp;
    assign w_ticks_ext = CMP_BITS'(w_ticks);
    assign w_period    = (w_ticks_ext > CMP_BITS'(r_period_limit)) ? r_period_limit
                                                                    : w_ticks_ext[23:0];

    assign o_status.skip_div = r_first || (w_period == '0);

    // restoring divide step, one quotient bit per cycle
    assign w_shift   = {r_rem, r_quo[NUM_BITS-1]};
    assign w_div_ext = {1'b0, r_div};
    assign w_ge      = (w_shift >= w_div_ext);

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_period <= w_period;
            r_div    <= DIV_BITS'(w_period);
            r_rem    <= '0;
            r_quo    <= r_numerator;
        end else if (i_cmd.div_step) begin
            r_rem <= w_ge ? DIV_BITS'(w_shift - w_div_ext) : w_shift[DIV_BITS-1:0];
            r_quo <= {r_quo[NUM_BITS-2:0], w_ge};
        end
    end

    // saturate quotient to 16 bits, then clamp, max test first; a zero period gives max speed
    assign w_sat = (|r_quo[NUM_BITS-1:SPD_BITS]) ? '1 : r_quo[SPD_BITS-1:0];

    always_comb begin
        if (r_period == '0) begin
            w_speed = r_max_speed;
        end else if (w_sat > r_max_speed) begin
            w_speed = r_max_speed;
        end else if (w_sat < r_min_speed) begin
            w_speed = r_min_speed;
        end else begin
            w_speed = w_sat;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_period    <= r_first ? '0 : r_period;
            r_out_speed     <= r_first ? '0 : w_speed;
            r_out_valid_res <= !r_first;
        end
    end

    assign o_period    = r_out_period;
    assign o_speed     = r_out_speed;
    assign o_valid_res = r_out_valid_res;

endmodule
